// ----- rtl/mas_pkg.sv -----
// Shared opcodes, status codes, field widths and scanner handshake types.
package mas_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 6;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 7;
    localparam int DIGIT_W  = 4;

    localparam logic [OPCODE_W-1:0] OP_LOAD   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SETBIT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SETALL = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // register index 0 holds the length in use
    localparam logic REG_LEN = 1'b0;

    typedef struct packed {
        logic start;   // load mask into the shifter and begin a pass
        logic find;    // 1: stop at the rank-th set bit, 0: count all bits
    } t_scan_cmd;

    typedef struct packed {
        logic busy;
        logic done;    // one-cycle pulse at the end of a pass
    } t_scan_sts;

endpackage

// ----- rtl/masked_array_select_core.sv -----
// Top level: masked word store with rank-select access and an APB length register.
//
// The block keeps MAX_SLOTS words of DATA_WIDTH bits, each with an activation
// bit, and takes one item at a time on the input channel, answering each with
// exactly one result item. Load, set bit and query address a physical slot
// directly and pass from accept through the execute and finish states to the
// result; set all bits takes the same path. Read active and write active walk
// the activation mask through a shift register one 4-bit digit per cycle until
// the index-th active slot is found, scanning up to ceil(MAX_SLOTS/4) digits,
// 16 at the default size, and then pass through the access state; that scan
// sets the rate. The active count is kept in a register and updated per item.
// Writing the length register (byte address 0) while idle clamps it to
// MAX_SLOTS, clears the mask bits at and above it and then recounts the mask;
// no item is accepted during the recount. Errors come back as status: empty
// array, no active items, index out of range; a failing item changes nothing.
// A finished result waits in the output register while the next item may be
// accepted. Words never written read back undefined.
module masked_array_select_core
    import mas_pkg::*;
#(
    parameter int MAX_SLOTS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item in
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [INDEX_W-1:0]   i_index,
    input  logic                 i_flag,
    input  logic [WORD_W-1:0]    i_word_in,
    // result out
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_W-1:0]    o_word_out,
    output logic                 o_bit_out,
    output logic [STATUS_W-1:0]  o_status,
    output logic [COUNT_W-1:0]   o_active_count,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int LW = $clog2(MAX_SLOTS + 1);
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int DW = DATA_WIDTH;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_ACCESS  = 3'd3;
    localparam logic [2:0] S_FIN     = 3'd4;
    localparam logic [2:0] S_RECOUNT = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [LW-1:0]         r_len;
    logic [LW-1:0]         r_count;
    logic [MAX_SLOTS-1:0]  r_mask;
    logic [DW-1:0]         r_mem [MAX_SLOTS];
    logic [DW-1:0]         r_rdata;

    // latched item
    logic [OPCODE_W-1:0]   r_op;
    logic [INDEX_W-1:0]    r_idx;
    logic                  r_flag;
    logic [DW-1:0]         r_word;

    // staged result
    logic                  r_res_bit;
    logic [STATUS_W-1:0]   r_res_status;

    // output register
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_word_out;
    logic                  r_bit_out;
    logic [STATUS_W-1:0]   r_status;
    logic [COUNT_W-1:0]    r_act;

    logic                  w_cfg_wr;
    logic                  w_len_wr;
    logic [LW-1:0]         w_cfg_len;
    logic [MAX_SLOTS-1:0]  w_cfg_mask;
    logic [MAX_SLOTS-1:0]  w_len_mask;
    logic                  w_accept;
    logic                  w_phys_ok;
    logic                  w_go_scan;
    logic                  w_out_free;
    logic [AW-1:0]         w_pslot;
    logic                  w_old_bit;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_addr;

    t_scan_cmd             w_cmd;
    t_scan_sts             w_sts;
    logic [AW-1:0]         w_slot;
    logic [LW-1:0]         w_total;
    logic [MAX_SLOTS-1:0]  w_scan_mask;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_len_wr = w_cfg_wr && (paddr[2] == REG_LEN);
    assign prdata   = (paddr[2] == REG_LEN) ? 32'(r_len) : 32'd0;

    // values above the slot count saturate
    assign w_cfg_len = (int'(pwdata[CFG_W-1:0]) > MAX_SLOTS) ? LW'(MAX_SLOTS)
                                                           : LW'(pwdata[CFG_W-1:0]);

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            w_cfg_mask[i] = r_mask[i] && (i < int'(w_cfg_len));
            w_len_mask[i] = (i < int'(r_len));
        end
    end

    // ---------------- item decode ----------------
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !w_len_wr;
    assign w_pslot    = AW'(r_idx);
    assign w_phys_ok  = int'(r_idx) < int'(r_len);
    assign w_old_bit  = r_mask[w_pslot];
    assign w_go_scan  = ((r_op == OP_READ) || (r_op == OP_WRITE)) && (r_len != '0) &&
                        (r_count != '0) && (int'(r_idx) < int'(r_count));
    assign w_out_free = !r_out_valid || i_out_ready;

    // ---------------- scanner ----------------
    assign w_cmd.start = ((r_state == S_IDLE) && w_len_wr) ||
                         ((r_state == S_EXEC) && w_go_scan);
    assign w_cmd.find  = (r_state == S_EXEC);
    assign w_scan_mask = (r_state == S_IDLE) ? w_cfg_mask : r_mask;

    mas_scan #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_mask  (w_scan_mask),
        .i_rank  (LW'(r_idx)),
        .o_sts   (w_sts),
        .o_slot  (w_slot),
        .o_total (w_total)
    );

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_len_wr) begin
                    n_state = S_RECOUNT;
                end else if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:    n_state = w_go_scan ? S_SCAN : S_FIN;
            S_SCAN:    n_state = w_sts.done ? S_ACCESS : S_SCAN;
            S_ACCESS:  n_state = S_FIN;
            S_FIN:     n_state = w_out_free ? S_IDLE : S_FIN;
            S_RECOUNT: n_state = w_sts.done ? S_IDLE : S_RECOUNT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- mask, length and count ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LW'(MAX_SLOTS);
            r_count <= LW'(MAX_SLOTS);
            r_mask  <= '1;
        end else if ((r_state == S_IDLE) && w_len_wr) begin
            r_len  <= w_cfg_len;
            r_mask <= w_cfg_mask;
        end else if ((r_state == S_RECOUNT) && w_sts.done) begin
            r_count <= w_total;
        end else if ((r_state == S_EXEC) && (r_len != '0)) begin
            if ((r_op == OP_SETBIT) && w_phys_ok) begin
                r_mask[w_pslot] <= r_flag;
                if (r_flag && !w_old_bit) begin
                    r_count <= r_count + LW'(1);
                end else if (!r_flag && w_old_bit) begin
                    r_count <= r_count - LW'(1);
                end
            end else if (r_op == OP_SETALL) begin
                r_mask  <= r_flag ? (r_mask | w_len_mask) : (r_mask & ~w_len_mask);
                r_count <= r_flag ? r_len : '0;
            end
        end
    end

    // ---------------- item capture and result staging ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_opcode;
            r_idx  <= i_index;
            r_flag <= i_flag;
            r_word <= DW'(i_word_in);
        end
        if (r_state == S_EXEC) begin
            r_res_bit    <= 1'b0;
            r_res_status <= ST_OK;
            if ((r_op <= OP_WRITE) && (r_len == '0)) begin
                r_res_status <= ST_EMPTY;
            end else begin
                case (r_op) inside
                    OP_LOAD, OP_SETBIT, OP_QUERY: begin
                        if (!w_phys_ok) begin
                            r_res_status <= ST_RANGE;
                        end else if (r_op != OP_LOAD) begin
                            r_res_bit <= w_old_bit;
                        end
                    end
                    OP_READ, OP_WRITE: begin
                        if (r_count == '0) begin
                            r_res_status <= ST_NONE;
                        end else if (!w_go_scan) begin
                            r_res_status <= ST_RANGE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // ---------------- word store ----------------
    assign w_mem_we = ((r_state == S_EXEC) && (r_op == OP_LOAD) && (r_len != '0) &&
                       w_phys_ok) ||
                      ((r_state == S_ACCESS) && (r_op == OP_WRITE));
    assign w_mem_addr = (r_state == S_EXEC) ? w_pslot : w_slot;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= r_word;
        end
        r_rdata <= r_mem[w_slot];
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            r_word_out <= ((r_op == OP_READ) && (r_res_status == ST_OK)) ?
                          WORD_W'(r_rdata) : '0;
            r_bit_out  <= r_res_bit;
            r_status   <= r_res_status;
            r_act      <= COUNT_W'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_out     = r_word_out;
    assign o_bit_out      = r_bit_out;
    assign o_status       = r_status;
    assign o_active_count = r_act;

    // ---------------- assertions ----------------
    // the kept count matches the mask whenever the block waits for an item
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_mask) == int'(r_count)))
        else $error("active count out of step with mask");

    // no mask bit survives at or above the length in use
    a_mask_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_mask & ~w_len_mask) == '0))
        else $error("mask bit set beyond length");

    // scanner finishes only in the states that wait for it
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> ((r_state == S_SCAN) || (r_state == S_RECOUNT)))
        else $error("stray scanner completion");

    // scanner is quiet while the block is idle
    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_sts.busy)
        else $error("scanner busy while idle");

endmodule

// ----- rtl/mas_scan.sv -----
// Digit-serial mask scanner: population count or select of the rank-th set bit.
module mas_scan
    import mas_pkg::*;
#(
    parameter int MAX_SLOTS = 64
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  t_scan_cmd                                         i_cmd,
    input  logic [MAX_SLOTS-1:0]                              i_mask,
    input  logic [$clog2(MAX_SLOTS + 1)-1:0]                  i_rank,
    output t_scan_sts                                         o_sts,
    output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] o_slot,
    output logic [$clog2(MAX_SLOTS + 1)-1:0]                  o_total
);

    localparam int LW  = $clog2(MAX_SLOTS + 1);
    localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int ND  = (MAX_SLOTS + DIGIT_W - 1) / DIGIT_W;
    localparam int PW  = ND * DIGIT_W;
    localparam int DGW = (ND > 1) ? $clog2(ND) : 1;

    logic [PW-1:0]      r_scan;
    logic [DGW-1:0]     r_dig;
    logic [LW-1:0]      r_seen;
    logic [LW-1:0]      r_rank;
    logic               r_find;
    logic               r_busy;
    logic               r_done;
    logic [AW-1:0]      r_slot;

    logic [DIGIT_W-1:0] w_digit;
    logic [2:0]         w_pop;
    logic [LW:0]        w_sum;
    logic               w_hit;
    logic [1:0]         w_krem;
    logic [1:0]         w_pos;
    logic [1:0]         w_cnt;
    logic               w_found;

    assign w_digit = r_scan[DIGIT_W-1:0];
    assign w_pop   = 3'(w_digit[0]) + 3'(w_digit[1]) + 3'(w_digit[2]) + 3'(w_digit[3]);
    assign w_sum   = (LW+1)'(r_seen) + (LW+1)'(w_pop);
    assign w_hit   = r_find && (w_sum > (LW+1)'(r_rank));
    assign w_krem  = 2'(r_rank - r_seen);

    // position of the krem-th set bit inside the current digit
    always_comb begin
        w_pos   = 2'd0;
        w_cnt   = 2'd0;
        w_found = 1'b0;
        for (int j = 0; j < DIGIT_W; j++) begin
            if (w_digit[j] && !w_found && (w_cnt == w_krem)) begin
                w_pos   = 2'(j);
                w_found = 1'b1;
            end
            w_cnt = w_cnt + 2'(w_digit[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (w_hit || (r_dig == DGW'(ND - 1)))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scan <= PW'(i_mask);
            r_dig  <= '0;
            r_seen <= '0;
            r_rank <= i_rank;
            r_find <= i_cmd.find;
        end else if (r_busy) begin
            if (w_hit) begin
                r_slot <= AW'({r_dig, w_pos});
            end else begin
                r_seen <= LW'(w_sum);
                r_scan <= r_scan >> DIGIT_W;
                r_dig  <= r_dig + DGW'(1);
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_slot     = r_slot;
    assign o_total    = r_seen;

endmodule
